/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* hw/rtl/ddpt_pkg.sv */
`default_nettype none
package ddpt_pkg;
	localparam int TEMP_W = 11;
	localparam int DAY_W = 16;
	localparam int LIM_W = 13;
	localparam int DD_W = 11;
	localparam int BBCH_W = 15;
	localparam int NUM_STAGES = 5;

	localparam logic [2:0] REG_START_DAY = 3'd0;
	localparam logic [2:0] REG_BASE_TEMP = 3'd1;
	localparam logic [2:0] REG_LIM_BUD   = 3'd2;
	localparam logic [2:0] REG_LIM_FLOW  = 3'd3;
	localparam logic [2:0] REG_LIM_VER   = 3'd4;
	localparam logic [2:0] REG_LIM_RIPE  = 3'd5;
	localparam logic [2:0] REG_BBCH_MODE = 3'd6;

	typedef struct packed {
		logic logic_start;   // latch item, compute degree-days
		logic div_dd_start;  // start degree-day division
		logic div_ph_start;  // start phase increment division
		logic update;        // update phase and stage days
		logic out_load;      // load result register
	} ddpt_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic dd_needs_div;  // triangle form selected
		logic ph_needs_div;  // stage 1..4 with positive span, not missing
	} ddpt_stat_t;

	// BBCH scale per stage: base and slope.
	function automatic logic [6:0] bbch_base(input logic [2:0] s);
		unique case (s)
			3'd2: bbch_base = 7'd8;
			3'd3: bbch_base = 7'd61;
			3'd4: bbch_base = 7'd83;
			3'd5: bbch_base = 7'd87;
			default: bbch_base = 7'd0;
		endcase
	endfunction

	function automatic logic [5:0] bbch_slope(input logic [2:0] s);
		unique case (s)
			3'd1: bbch_slope = 6'd8;
			3'd2: bbch_slope = 6'd53;
			3'd3: bbch_slope = 6'd22;
			3'd4: bbch_slope = 6'd4;
			default: bbch_slope = 6'd0;
		endcase
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/ddpt_stream_if.sv */
`default_nettype none
interface ddpt_stream_if #(
	parameter int W = 8
);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/degree_day_phenology_tracker.sv */
`default_nettype none
// Degree-day phenology tracker.
// One input transaction per day on in_ch: min/max temperature (1/16 degC),
// day number and a missing flag. One result transaction per day on out_ch:
// phase (stage plus fraction), BBCH value and valid flag, stage entered,
// held missing flag, degree-days and the recorded entry day of each stage.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while the block is idle; the block does not enforce it.
// Each day is latched, then passes up to twice through the shared restoring
// divider (triangle degree-days, phase increment), then the phase is updated
// and the result loaded into the output register. The divider sets the rate;
// one day is in flight at a time, and in_ch is ready again once the result is
// in the output register.
// Reset clears the phase to stage 0, all recorded days to zero and loads the
// default configuration. If the receiver stalls, the result holds in the
// output register and the next day waits in the datapath until it drains.
module degree_day_phenology_tracker #(
	parameter int PHASE_FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [15:0] cfg_data,
	ddpt_stream_if.sink in_ch,
	ddpt_stream_if.source out_ch
);
	localparam int PW = PHASE_FRAC_BITS + 3;

	ddpt_pkg::ddpt_cmd_t cmd;
	ddpt_pkg::ddpt_stat_t stat;
	logic in_ready, out_valid_q, in_fire;

	assign in_ch.ready = in_ready;
	assign in_fire = in_ch.valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end
	assign out_ch.valid = out_valid_q;

	ddpt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_valid(out_valid_q),
		.out_ready(out_ch.ready), .stat(stat), .in_ready(in_ready), .cmd(cmd)
	);

	logic [PW-1:0] ph;
	logic [14:0] bb;
	logic bv, hm;
	logic [2:0] se;
	logic [10:0] dd;
	logic [15:0] d0, d1, d2, d3, d4;

	ddpt_datapath #(.PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.min_temperature(in_ch.data[10:0]), .max_temperature(in_ch.data[21:11]),
		.day_number(in_ch.data[37:22]), .temp_missing(in_ch.data[38]),
		.phase_value(ph), .bbch_value(bb), .bbch_valid(bv), .stage_entered(se),
		.held_missing(hm), .degree_days(dd), .start_day_seen(d0),
		.budburst_day(d1), .flowering_day(d2), .veraison_day(d3), .ripening_day(d4)
	);

	assign out_ch.data = {d4, d3, d2, d1, d0, dd, hm, se, bv, bb, ph};
endmodule
`default_nettype wire

/* hw/rtl/ddpt_divider.sv */
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle.
module ddpt_divider #(
	parameter int NW = 40,
	parameter int DW = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [NW-1:0] num,
	input wire logic [DW-1:0] den,
	output logic busy,
	output logic [NW-1:0] quot
);
	localparam int CW = $clog2(NW + 1);
	logic [CW-1:0] cnt_q;
	logic [DW:0] rem_q;
	logic [NW-1:0] q_q;
	logic [DW-1:0] den_q;
	logic [DW:0] trial;
	logic [DW:0] shifted;

	assign shifted = {rem_q[DW-1:0], q_q[NW-1]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (!trial[DW]) begin
				rem_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = q_q;
endmodule
`default_nettype wire

/* hw/rtl/ddpt_ctrl.sv */
`default_nettype none
`include "assert_macros.svh"
module ddpt_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_fire,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire ddpt_pkg::ddpt_stat_t stat,
	output logic in_ready,
	output ddpt_pkg::ddpt_cmd_t cmd
);
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DD     = 3'd1;
	localparam logic [2:0] ST_DDWAIT = 3'd2;
	localparam logic [2:0] ST_PH     = 3'd3;
	localparam logic [2:0] ST_PHWAIT = 3'd4;
	localparam logic [2:0] ST_UPD    = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.logic_start = 1'b1;
					state_d = ST_DD;
				end
			end
			ST_DD: begin
				if (stat.dd_needs_div) begin
					cmd.div_dd_start = 1'b1;
					state_d = ST_DDWAIT;
				end else begin
					state_d = ST_PH;
				end
			end
			ST_DDWAIT: if (!stat.div_busy) state_d = ST_PH;
			ST_PH: begin
				if (stat.ph_needs_div) begin
					cmd.div_ph_start = 1'b1;
					state_d = ST_PHWAIT;
				end else begin
					state_d = ST_UPD;
				end
			end
			ST_PHWAIT: if (!stat.div_busy) state_d = ST_UPD;
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	`ASSERT_IMPL(a_idle_only_accept, clk, arst_n, in_fire, state_q == ST_IDLE,
		"transaction accepted while busy")
	`ASSERT_NEXT(a_upd_then_out, clk, arst_n, cmd.update, state_q == ST_OUT,
		"update not followed by output")
	`ASSERT_IMPL(a_div_start_free, clk, arst_n, cmd.div_dd_start || cmd.div_ph_start,
		!stat.div_busy, "divider started while busy")
endmodule
`default_nettype wire

/* hw/rtl/ddpt_datapath.sv */
`default_nettype none
`include "assert_macros.svh"
module ddpt_datapath #(
	parameter int PHASE_FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire ddpt_pkg::ddpt_cmd_t cmd,
	output ddpt_pkg::ddpt_stat_t stat,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [15:0] cfg_data,
	input wire logic signed [10:0] min_temperature,
	input wire logic signed [10:0] max_temperature,
	input wire logic [15:0] day_number,
	input wire logic temp_missing,
	output logic [PHASE_FRAC_BITS+2:0] phase_value,
	output logic [14:0] bbch_value,
	output logic bbch_valid,
	output logic [2:0] stage_entered,
	output logic held_missing,
	output logic [10:0] degree_days,
	output logic [15:0] start_day_seen,
	output logic [15:0] budburst_day,
	output logic [15:0] flowering_day,
	output logic [15:0] veraison_day,
	output logic [15:0] ripening_day
);
	localparam int F = PHASE_FRAC_BITS;
	localparam int PW = F + 3;
	// Numerator of the phase division: dd (11 bits) << F; also holds the 22-bit d*d.
	localparam int NW = (11 + F > 22) ? 11 + F : 22;
	localparam int DW = 17;

	// Configuration registers.
	logic [15:0] start_day_q;
	logic signed [10:0] base_q;
	logic [12:0] lim_q [4];
	logic mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_day_q <= '0;
			base_q <= 11'sd160;
			lim_q[0] <= 13'd100;
			lim_q[1] <= 13'd400;
			lim_q[2] <= 13'd1000;
			lim_q[3] <= 13'd1400;
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ddpt_pkg::REG_START_DAY: start_day_q <= cfg_data;
				ddpt_pkg::REG_BASE_TEMP: base_q <= cfg_data[10:0];
				ddpt_pkg::REG_LIM_BUD: lim_q[0] <= cfg_data[12:0];
				ddpt_pkg::REG_LIM_FLOW: lim_q[1] <= cfg_data[12:0];
				ddpt_pkg::REG_LIM_VER: lim_q[2] <= cfg_data[12:0];
				ddpt_pkg::REG_LIM_RIPE: lim_q[3] <= cfg_data[12:0];
				ddpt_pkg::REG_BBCH_MODE: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Latched item and derived quantities.
	logic signed [11:0] tn_q, tx_q, base_x_q;
	logic [15:0] day_q;
	logic miss_q;
	logic tri_q;
	logic [10:0] dd_q;

	logic signed [11:0] tn_w, tx_w, bs_w;
	logic signed [13:0] mean_s;
	logic tri_w;
	assign tn_w = 12'(min_temperature);
	assign tx_w = 12'(max_temperature);
	assign bs_w = 12'(base_q);
	assign tri_w = (tn_w < bs_w) && (tx_w > bs_w);
	assign mean_s = 14'(tx_w) + 14'(tn_w) - 14'(bs_w) - 14'(bs_w);

	// Phase state.
	logic [PW-1:0] phase_q;
	logic [15:0] sdays_q [ddpt_pkg::NUM_STAGES];
	logic [2:0] stage;
	assign stage = 3'(phase_q >> F);

	logic signed [13:0] lo, span;
	always_comb begin
		lo = (stage == 3'd1) ? 14'sd0 : 14'($unsigned(lim_q[2'(stage - 3'd2)]));
		span = 14'($unsigned(lim_q[2'(stage - 3'd1)])) - lo;
	end
	logic in_run;
	assign in_run = (stage >= 3'd1) && (stage <= 3'd4);

	// Shared divider.
	logic dv_start, dv_busy;
	logic [NW-1:0] dv_num, dv_quot;
	logic [DW-1:0] dv_den;
	logic [10:0] d_tri;
	assign d_tri = 11'(tx_q - base_x_q);

	always_comb begin
		if (cmd.div_dd_start) begin
			dv_num = NW'({11'd0, d_tri} * {11'd0, d_tri});
			dv_den = DW'({(tx_q - tn_q), 1'b0});
		end else begin
			dv_num = NW'(dd_q) << F;
			dv_den = DW'({span[12:0], 4'd0});
		end
	end
	assign dv_start = cmd.div_dd_start || cmd.div_ph_start;

	ddpt_divider #(.NW(NW), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(dv_num), .den(dv_den),
		.busy(dv_busy), .quot(dv_quot)
	);

	logic dd_div_q;
	logic [PW-1:0] inc_q;

	always_ff @(posedge clk) begin
		if (cmd.logic_start) begin
			tn_q <= tn_w;
			tx_q <= tx_w;
			base_x_q <= bs_w;
			day_q <= day_number;
			miss_q <= temp_missing;
			tri_q <= tri_w;
			dd_q <= (mean_s <= 0) ? 11'd0 : 11'(mean_s >>> 1);
		end else if (dd_div_q && !dv_busy && !cmd.div_ph_start && !cmd.update) begin
			// Capture the triangle result once its division is done.
			dd_q <= 11'(dv_quot);
		end
		if (cmd.div_dd_start) dd_div_q <= 1'b1;
		else if (cmd.div_ph_start || cmd.logic_start) dd_div_q <= 1'b0;
		// A quotient too wide for the phase always reaches the stage target.
		if (cmd.logic_start) inc_q <= '0;
		else if (!dd_div_q && !dv_busy && stat.ph_needs_div && !cmd.div_ph_start)
			inc_q <= (|dv_quot[NW-1:PW]) ? '1 : dv_quot[PW-1:0];
	end

	assign stat.div_busy = dv_busy;
	assign stat.dd_needs_div = tri_q;
	assign stat.ph_needs_div = !miss_q && in_run && (span > 0);

	// Next phase.
	logic [PW:0] target, nxt;
	logic [2:0] ent_w;
	assign target = (PW + 1)'(stage + 3'd1) << F;
	always_comb begin
		nxt = {1'b0, phase_q};
		ent_w = 3'd0;
		if (!miss_q) begin
			if (stage == 3'd0) begin
				if (day_q == start_day_q) begin
					nxt = (PW + 1)'(1) << F;
					ent_w = 3'd1;
				end
			end else if (in_run) begin
				nxt = (span > 0) ? {1'b0, phase_q} + {1'b0, inc_q} : target;
				if (nxt >= target) begin
					nxt = target;
					ent_w = stage + 3'd1;
				end
			end
		end
	end

	logic [2:0] ent_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			for (int i = 0; i < ddpt_pkg::NUM_STAGES; i++) sdays_q[i] <= '0;
		end else if (cmd.update) begin
			phase_q <= nxt[PW-1:0];
			if (ent_w != 3'd0) sdays_q[3'(ent_w - 3'd1)] <= day_q;
		end
	end
	always_ff @(posedge clk) if (cmd.update) ent_q <= ent_w;

	// BBCH mapping.
	logic [F-1:0] frac;
	logic [14:0] bbch_w;
	logic [F+13:0] prod;
	assign frac = phase_q[F-1:0];
	assign prod = (F + 14)'(ddpt_pkg::bbch_slope(stage)) * (F + 14)'(frac) * (F + 14)'(256);
	always_comb begin
		if (mode_q) begin
			if (stage == 3'd0) bbch_w = '0;
			else if (stage >= 3'd5) bbch_w = 15'(87 * 256);
			else bbch_w = 15'({ddpt_pkg::bbch_base(stage), 8'd0}) + 15'(prod >> F);
		end else begin
			bbch_w = 15'(({phase_q, 8'd0}) >> F);
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			phase_value <= phase_q;
			bbch_value <= bbch_w;
			bbch_valid <= !(mode_q && stage == 3'd0);
			stage_entered <= ent_q;
			held_missing <= miss_q;
			degree_days <= miss_q ? 11'd0 : dd_q;
			start_day_seen <= sdays_q[0];
			budburst_day <= sdays_q[1];
			flowering_day <= sdays_q[2];
			veraison_day <= sdays_q[3];
			ripening_day <= sdays_q[4];
		end
	end

	`ASSERT_IMPL(a_phase_max, clk, arst_n, 1'b1, stage <= 3'd5, "phase above final stage")
	`ASSERT_NEXT(a_miss_hold, clk, arst_n, cmd.update && miss_q, $stable(phase_q),
		"phase moved on a missing day")
	`ASSERT_IMPL(a_span_pos, clk, arst_n, cmd.div_ph_start, span > 0,
		"phase division started with an empty span")
endmodule
`default_nettype wire

/* sim/ddpt_phenology_checker.sv */
module ddpt_phenology_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [15:0] cfg_data,
	ddpt_stream_if in_mon,
	ddpt_stream_if out_mon,
	output int fail_count,
	output int pending
);
	localparam int FRAC = 16;
	localparam int FIFO_DEPTH = 16;

	typedef struct packed {
		logic missing;
		logic [15:0] day;
		logic signed [10:0] tmax;
		logic signed [10:0] tmin;
	} day_obs_t;

	typedef struct packed {
		logic [4:0][15:0] days;
		logic [10:0] dd;
		logic held;
		logic [2:0] entered;
		logic valid;
		logic [14:0] bbch;
		logic [18:0] phase;
	} day_result_t;

	// Configuration copy.
	logic [15:0] start_day;
	logic signed [10:0] base_t;
	logic [12:0] lim [4];
	logic scale_mode;

	// Season state.
	longint phase;
	logic [15:0] entry_day [5];

	// Expected results in order of acceptance.
	day_result_t expected_days [FIFO_DEPTH];
	logic [3:0] wr_ptr, rd_ptr;
	int level;

	function automatic longint bbch_of(longint ph);
		longint st, fr, b, s;
		st = ph >> FRAC;
		fr = ph & ((64'd1 << FRAC) - 1);
		case (st)
			1: begin b = 0; s = 8; end
			2: begin b = 8; s = 53; end
			3: begin b = 61; s = 22; end
			default: begin b = 83; s = 4; end
		endcase
		if (st >= 5)
			return 87 * 256;
		return b * 256 + ((s * 256 * fr) >> FRAC);
	endfunction

	function automatic day_result_t advance_season(day_obs_t d);
		day_result_t r;
		int tn, tx, b, s, lo, span;
		longint dd, st, tgt, nxt;
		tn = d.tmin;
		tx = d.tmax;
		b = base_t;
		dd = 0;
		r = '0;
		if (!d.missing) begin
			if (tn < b && tx > b) begin
				dd = ((tx - b) * (tx - b)) / (2 * (tx - tn));
			end else begin
				s = tx + tn - 2 * b;
				dd = (s <= 0) ? 0 : s / 2;
			end
			st = phase >> FRAC;
			if (st == 0) begin
				if (d.day == start_day) begin
					phase = 64'd1 << FRAC;
					entry_day[0] = d.day;
					r.entered = 1;
				end
			end else if (st <= 4) begin
				lo = (st == 1) ? 0 : int'(lim[st - 2]);
				span = int'(lim[st - 1]) - lo;
				tgt = (st + 1) << FRAC;
				if (span <= 0)
					nxt = tgt;
				else
					nxt = phase + ((dd << FRAC) / (16 * span));
				if (nxt >= tgt) begin
					nxt = tgt;
					entry_day[st] = d.day;
					r.entered = st + 1;
				end
				phase = nxt;
			end
		end
		st = phase >> FRAC;
		r.valid = 1'b1;
		if (scale_mode) begin
			if (st == 0) begin
				r.bbch = '0;
				r.valid = 1'b0;
			end else begin
				r.bbch = bbch_of(phase);
			end
		end else begin
			r.bbch = (phase * 256) >> FRAC;
		end
		r.phase = phase;
		r.held = d.missing;
		r.dd = dd;
		for (int i = 0; i < 5; i++)
			r.days[i] = entry_day[i];
		return r;
	endfunction

	function automatic int field_ok(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
			return 0;
		end
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		day_result_t e, a;
		bit ok;
		if (!arst_n) begin
			start_day = 16'd0;
			base_t = 11'sd160;
			lim[0] = 13'd100;
			lim[1] = 13'd400;
			lim[2] = 13'd1000;
			lim[3] = 13'd1400;
			scale_mode = 1'b0;
			phase = 0;
			for (int i = 0; i < 5; i++)
				entry_day[i] = '0;
			wr_ptr = '0;
			rd_ptr = '0;
			level = 0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				a = out_mon.data;
				if (level == 0) begin
					$display("%0t: result transaction with none expected: %h", $time, a);
					fail_count++;
				end else begin
					e = expected_days[rd_ptr];
					rd_ptr = rd_ptr + 4'd1;
					level--;
					ok = 1;
					ok &= field_ok("phase_value", e.phase, a.phase);
					ok &= field_ok("bbch_value", e.bbch, a.bbch);
					ok &= field_ok("bbch_valid", e.valid, a.valid);
					ok &= field_ok("stage_entered", e.entered, a.entered);
					ok &= field_ok("held_missing", e.held, a.held);
					ok &= field_ok("degree_days", e.dd, a.dd);
					for (int i = 0; i < 5; i++)
						ok &= field_ok($sformatf("stage_day[%0d]", i), e.days[i], a.days[i]);
					if (!ok)
						fail_count++;
				end
			end
			if (in_mon.valid && in_mon.ready) begin
				expected_days[wr_ptr] = advance_season(in_mon.data);
				wr_ptr = wr_ptr + 4'd1;
				level++;
			end
			if (cfg_we) begin
				case (cfg_index)
					ddpt_pkg::REG_START_DAY: start_day = cfg_data;
					ddpt_pkg::REG_BASE_TEMP: base_t = cfg_data[10:0];
					ddpt_pkg::REG_LIM_BUD: lim[0] = cfg_data[12:0];
					ddpt_pkg::REG_LIM_FLOW: lim[1] = cfg_data[12:0];
					ddpt_pkg::REG_LIM_VER: lim[2] = cfg_data[12:0];
					ddpt_pkg::REG_LIM_RIPE: lim[3] = cfg_data[12:0];
					ddpt_pkg::REG_BBCH_MODE: scale_mode = cfg_data[0];
					default: ;
				endcase
			end
			pending = level;
		end
	end
endmodule

/* sim/degree_day_phenology_tracker_tb.sv */
module degree_day_phenology_tracker_tb;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 100;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	int fail_count;
	int pending;
	int send_idle;
	int recv_stall;
	int cycles = 0;
	logic [15:0] day_cnt;

	ddpt_stream_if #(.W(39)) in_ch ();
	ddpt_stream_if #(.W(130)) out_ch ();

	degree_day_phenology_tracker u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	ddpt_phenology_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_mon(in_ch),
		.out_mon(out_ch),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk)
		out_ch.ready = ($urandom_range(99) >= recv_stall);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("degree_day_phenology_tracker_tb: FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_day(logic [10:0] tmin, logic [10:0] tmax, logic [15:0] day,
			logic missing);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data = {missing, day, tmax, tmin};
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	task automatic send_random_day();
		int tmin, tmax;
		logic [15:0] day;
		if ($urandom_range(9) < 8) begin
			tmin = $urandom_range(400) - 100;
			tmax = tmin + $urandom_range(300);
		end else begin
			tmin = $urandom_range(2047);
			tmax = $urandom_range(2047);
		end
		day_cnt = day_cnt + 1;
		day = ($urandom_range(19) == 0) ? 16'($urandom) : day_cnt;
		send_day(11'(tmin), 11'(tmax), day, $urandom_range(9) == 0);
	endtask

	task automatic set_limits(int a, int b, int c, int d);
		write_reg(ddpt_pkg::REG_LIM_BUD, 16'(a));
		write_reg(ddpt_pkg::REG_LIM_FLOW, 16'(b));
		write_reg(ddpt_pkg::REG_LIM_VER, 16'(c));
		write_reg(ddpt_pkg::REG_LIM_RIPE, 16'(d));
	endtask

	initial begin
		send_idle = 0;
		recv_stall = 0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		day_cnt = 16'd2000;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Stage 0 with the reset configuration, then in scale mode.
		send_day(11'sd100, 11'sd300, 16'd5, 1'b0);
		send_day(-11'sd800, 11'sd960, 16'hFFFF, 1'b0);
		send_day(11'sd960, -11'sd800, 16'd1, 1'b0);
		send_day(11'h3FF, 11'h400, 16'd2, 1'b0);
		send_day(11'sd200, 11'sd200, 16'd3, 1'b1);
		send_day(11'sd160, 11'sd160, 16'd4, 1'b0);
		drain();
		write_reg(ddpt_pkg::REG_BBCH_MODE, 16'd1);
		write_reg(ddpt_pkg::REG_START_DAY, 16'd2003);
		write_reg(ddpt_pkg::REG_BASE_TEMP, 16'h7FF);
		send_day(11'sd960, 11'sd960, 16'd2002, 1'b0);
		send_day(11'h7FF, 11'h3FF, 16'd0, 1'b0);
		// Missing temperature on the start day holds stage 0.
		send_day(11'sd200, 11'sd400, 16'd2003, 1'b1);
		send_day(11'sd200, 11'sd400, 16'd2003, 1'b0);
		send_day(11'sd200, 11'sd400, 16'd2003, 1'b0);
		drain();
		write_reg(ddpt_pkg::REG_BASE_TEMP, 16'd160);
		set_limits(8191, 8191, 8191, 8191);
		// Equal limits give zero spans that skip stages 2 to 4 and end the season; keep it long here.
		set_limits(3000, 6000, 8000, 8191);
		send_day(-11'sd800, -11'sd800, 16'd2004, 1'b0);
		send_day(11'sd960, 11'sd960, 16'd2005, 1'b0);
		send_day(11'sd100, 11'sd300, 16'd2006, 1'b0);
		send_day(11'sd0, 11'sd320, 16'd2007, 1'b1);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 59; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 59; end
				default: begin send_idle = 6; recv_stall = 6; end
			endcase
			write_reg(ddpt_pkg::REG_BBCH_MODE, 16'(ph % 2));
			write_reg(ddpt_pkg::REG_START_DAY, (ph == 3) ? 16'hFFFF : 16'($urandom));
			case (ph)
				0: write_reg(ddpt_pkg::REG_BASE_TEMP, 16'h400);
				1: write_reg(ddpt_pkg::REG_BASE_TEMP, 16'h3FF);
				2: write_reg(ddpt_pkg::REG_BASE_TEMP, 16'($signed(-11'sd800)));
				3: write_reg(ddpt_pkg::REG_BASE_TEMP, 16'd960);
				default: write_reg(ddpt_pkg::REG_BASE_TEMP, 16'($urandom_range(200)));
			endcase
			if (ph < 6)
				set_limits(0, $urandom_range(2000, 8191), $urandom_range(8191),
					$urandom_range(8191));
			else if (ph == 6)
				set_limits(8191, 8191, 0, 0);
			else
				set_limits(0, 0, 0, 0);
			// Keep the season in early stages for most phases by stretching spans.
			if (ph < 6)
				set_limits(ph * 400, 3000 + ph * 800, 6000 + ph * 300, 8191);
			for (int i = 0; i < 205; i++) begin
				if (ph == 2 && i == 100)
					drain();
				send_random_day();
			end
			in_ch.valid = 1'b0;
			drain();
		end

		if (fail_count == 0)
			$display("degree_day_phenology_tracker_tb: PASS");
		else
			$display("degree_day_phenology_tracker_tb: FAIL");
		$finish;
	end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ddpt_pkg.sv
hw/rtl/ddpt_stream_if.sv
hw/rtl/ddpt_divider.sv
hw/rtl/ddpt_ctrl.sv
hw/rtl/ddpt_datapath.sv
hw/rtl/degree_day_phenology_tracker.sv
sim/ddpt_phenology_checker.sv
sim/degree_day_phenology_tracker_tb.sv
